@@ hw/rtl/ipcidr_pkg.sv @@
package ipcidr_pkg;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // accumulator limits
   localparam int unsigned ACC_W        = 9;
   localparam logic [ACC_W-1:0] ACC_MAX  = 9'd511;
   localparam logic [ACC_W-1:0] OCTET_MAX = 9'd255;
   localparam logic [ACC_W-1:0] MASK_MAX  = 9'd32;
   localparam logic [1:0] LAST_OCTET     = 2'd3;

   // parse phase
   typedef enum logic [1:0] {
      PH_OCTET = 2'd0,
      PH_SLASH = 2'd1,
      PH_MASK  = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SYM   = 3'd1,
      ST_OCTET_BIG = 3'd2,
      ST_NO_MASK   = 3'd3,
      ST_MASK_BIG  = 3'd4
   } status_type;

   // per-string parse state
   typedef struct packed {
      phase_type        phase;
      logic [1:0]       octet_count;
      logic [ACC_W-1:0] accumulator;
      logic             digit_seen;
      logic [31:0]      address_shift;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:         PH_OCTET,
      octet_count:   2'd0,
      accumulator:   '0,
      digit_seen:    1'b0,
      address_shift: 32'd0
   };

   // one result
   typedef struct packed {
      status_type  status;
      logic [31:0] address;
      logic [5:0]  prefix_length;
   } result_type;

endpackage

@@ hw/rtl/ipcidr_step.sv @@
module ipcidr_step (
   input  ipcidr_pkg::parse_state_type cur,
   input  logic [7:0]                  character,
   output ipcidr_pkg::parse_state_type nxt,
   output logic                        emit,
   output ipcidr_pkg::result_type      result
);

   logic [7:0]                   digit;
   logic                         is_digit;
   logic                         is_nul;
   logic [12:0]                  acc_times_ten;
   logic [ipcidr_pkg::ACC_W-1:0] acc_added;
   ipcidr_pkg::status_type       status;
   logic [31:0]                  addr_pushed;
   ipcidr_pkg::parse_state_type  data_nxt;
   ipcidr_pkg::phase_type        phase_nxt;

   // digit decode and saturating multiply-by-ten accumulate
   always_comb begin
      digit         = character - ipcidr_pkg::CHAR_ZERO;
      is_digit      = (digit < 8'd10);
      is_nul        = (character == ipcidr_pkg::CHAR_NUL);
      acc_times_ten = {1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0}
                      + {9'd0, digit[3:0]};
      acc_added     = (acc_times_ten > {4'd0, ipcidr_pkg::ACC_MAX}) ?
                      ipcidr_pkg::ACC_MAX : acc_times_ten[ipcidr_pkg::ACC_W-1:0];
      addr_pushed   = {cur.address_shift[23:0], cur.accumulator[7:0]};
   end

   // data state update and decision
   always_comb begin
      emit                   = 1'b0;
      status                 = ipcidr_pkg::ST_OK;
      data_nxt.octet_count   = cur.octet_count;
      data_nxt.accumulator   = cur.accumulator;
      data_nxt.digit_seen    = cur.digit_seen;
      data_nxt.address_shift = cur.address_shift;
      data_nxt.phase         = cur.phase;
      case (cur.phase)
         ipcidr_pkg::PH_OCTET: begin
            if (is_digit) begin
               data_nxt.accumulator = acc_added;
               data_nxt.digit_seen  = 1'b1;
               if (acc_added > ipcidr_pkg::OCTET_MAX) begin
                  emit   = 1'b1;
                  status = ipcidr_pkg::ST_OCTET_BIG;
               end
            end else if (!cur.digit_seen) begin
               emit   = 1'b1;
               status = ipcidr_pkg::ST_BAD_SYM;
            end else if (cur.octet_count != ipcidr_pkg::LAST_OCTET) begin
               if (character != ipcidr_pkg::CHAR_DOT) begin
                  emit   = 1'b1;
                  status = ipcidr_pkg::ST_BAD_SYM;
               end else begin
                  data_nxt.address_shift = addr_pushed;
                  data_nxt.octet_count   = cur.octet_count + 2'd1;
                  data_nxt.accumulator   = '0;
                  data_nxt.digit_seen    = 1'b0;
               end
            end else if (character != ipcidr_pkg::CHAR_SLASH) begin
               emit   = 1'b1;
               status = ipcidr_pkg::ST_NO_MASK;
            end else begin
               data_nxt.address_shift = addr_pushed;
               data_nxt.accumulator   = '0;
               data_nxt.digit_seen    = 1'b0;
            end
         end
         ipcidr_pkg::PH_SLASH: begin
            if (is_nul) begin
               emit   = 1'b1;
               status = ipcidr_pkg::ST_NO_MASK;
            end else if (!is_digit) begin
               emit   = 1'b1;
               status = ipcidr_pkg::ST_BAD_SYM;
            end else begin
               data_nxt.accumulator = acc_added;
               data_nxt.digit_seen  = 1'b1;
               if (acc_added > ipcidr_pkg::MASK_MAX) begin
                  emit   = 1'b1;
                  status = ipcidr_pkg::ST_MASK_BIG;
               end
            end
         end
         ipcidr_pkg::PH_MASK: begin
            if (is_digit) begin
               data_nxt.accumulator = acc_added;
               data_nxt.digit_seen  = 1'b1;
               if (acc_added > ipcidr_pkg::MASK_MAX) begin
                  emit   = 1'b1;
                  status = ipcidr_pkg::ST_MASK_BIG;
               end
            end else begin
               emit   = 1'b1;
               status = ipcidr_pkg::ST_OK;
            end
         end
         default: begin
            // decided: drop text until the terminator
         end
      endcase

      // a terminator that ends the string starts over
      if ((emit || cur.phase == ipcidr_pkg::PH_DONE) && is_nul) begin
         data_nxt.octet_count   = 2'd0;
         data_nxt.accumulator   = '0;
         data_nxt.digit_seen    = 1'b0;
         data_nxt.address_shift = 32'd0;
      end
   end

   // next phase
   always_comb begin
      phase_nxt = cur.phase;
      case (cur.phase)
         ipcidr_pkg::PH_OCTET: begin
            if (!emit && !is_digit && cur.octet_count == ipcidr_pkg::LAST_OCTET)
               phase_nxt = ipcidr_pkg::PH_SLASH;
         end
         ipcidr_pkg::PH_SLASH: phase_nxt = ipcidr_pkg::PH_MASK;
         ipcidr_pkg::PH_MASK:  phase_nxt = ipcidr_pkg::PH_MASK;
         default:              phase_nxt = ipcidr_pkg::PH_DONE;
      endcase
      if (emit)
         phase_nxt = ipcidr_pkg::PH_DONE;
      if ((emit || cur.phase == ipcidr_pkg::PH_DONE) && is_nul)
         phase_nxt = ipcidr_pkg::PH_OCTET;
   end

   // full next state
   always_comb begin
      nxt       = data_nxt;
      nxt.phase = phase_nxt;
   end

   // result fields, zero on error
   always_comb begin
      result.status        = status;
      result.address       = (status == ipcidr_pkg::ST_OK) ? cur.address_shift : 32'd0;
      result.prefix_length = (status == ipcidr_pkg::ST_OK) ? cur.accumulator[5:0] : 6'd0;
   end

endmodule

@@ hw/rtl/ipv4_cidr_text_parser_core.sv @@
// channel   ports                                   direction
// request   req_valid, req_stall, req_character      in (req_stall out)
// response  rsp_valid, rsp_stall, rsp_status,
//           rsp_address, rsp_prefix_length          out (rsp_stall in)
//
// One character per cycle while rsp_stall is low; the character that decides a
// response passes the input register, then the response register, before it leaves.
// The parse state updates as a character moves from the input register into
// the response stage; the response register lets a new request in while a
// result waits. Synchronous active-high reset clears the parse state and
// both valid flags. rsp_stall holds the response and backs up to req_stall.
module ipv4_cidr_text_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_address,
   output logic [5:0]  rsp_prefix_length
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_char_ff, in_char_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ipcidr_pkg::result_type      rsp_data_ff, rsp_data_in;
   ipcidr_pkg::parse_state_type state_ff, state_in;
   ipcidr_pkg::parse_state_type step_nxt;
   ipcidr_pkg::result_type      step_result;
   logic                        step_emit;
   logic                        advance;
   logic                        req_accept;
   logic                        process;

   ipcidr_step u_step (
      .cur       (state_ff),
      .character (in_char_ff),
      .nxt       (step_nxt),
      .emit      (step_emit),
      .result    (step_result)
   );

   // handshake
   always_comb begin
      advance    = !rsp_valid_ff || !rsp_stall;
      req_stall  = in_valid_ff && !advance;
      req_accept = req_valid && !req_stall;
      process    = in_valid_ff && advance;
   end

   // next values
   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_char_in   = req_accept ? req_character : in_char_ff;
      state_in     = process ? step_nxt : state_ff;
      rsp_valid_in = advance ? (process && step_emit) : rsp_valid_ff;
      rsp_data_in  = (process && step_emit) ? step_result : rsp_data_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ipcidr_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_address       = rsp_data_ff.address;
   assign rsp_prefix_length = rsp_data_ff.prefix_length;

   // octet digits never hold a value past 255
   a_octet_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == ipcidr_pkg::PH_OCTET |-> state_ff.accumulator <= ipcidr_pkg::OCTET_MAX)
      else $error("octet accumulator out of range");

   // mask digits never hold a value past 32
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == ipcidr_pkg::PH_MASK |-> state_ff.accumulator <= ipcidr_pkg::MASK_MAX)
      else $error("mask accumulator out of range");

   // errors carry zero address and prefix
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ipcidr_pkg::ST_OK
      |-> rsp_data_ff.address == 32'd0 && rsp_data_ff.prefix_length == 6'd0)
      else $error("error response with nonzero payload");

   // a held character is not lost while the response stage is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("input register lost a pending character");

   // parse state only moves when a character is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(state_ff))
      else $error("parse state changed without a character");

endmodule

@@ tb/ipv4_cidr_text_parser_core_tb.sv @@
`timescale 1ns / 100ps

module ipv4_cidr_text_parser_core_tb;
   import ipcidr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_address;
   logic [5:0]  rsp_prefix_length;

   ipv4_cidr_text_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_prefix_length (rsp_prefix_length)
   );

   always #5 clock = ~clock;

   // parser shadow state
   phase_type        cur_phase;
   logic [1:0]       cur_octet;
   logic [ACC_W-1:0] cur_value;
   logic             cur_has_digit;
   logic [31:0]      cur_addr;

   result_type pending_results[$];
   int         fail_count = 0;
   int         parsed_chars = 0;

   // directed stimulus table
   logic [7:0] dir_chars[$];
   bit         dir_typed[$];
   result_type dir_results[$];

   logic [7:0] text_buf[$];

   function automatic void clear_parse();
      cur_phase     = PH_OCTET;
      cur_octet     = 2'd0;
      cur_value     = '0;
      cur_has_digit = 1'b0;
      cur_addr      = 32'd0;
   endfunction

   function automatic void add_digit(input logic [7:0] d);
      int unsigned v;
      v = cur_value * 10 + d;
      cur_value = (v > ACC_MAX) ? ACC_MAX : v[ACC_W-1:0];
      cur_has_digit = 1'b1;
   endfunction

   // outcome known: build the result, then restart or skip to the terminator
   function automatic bit decide(input status_type st, input logic [7:0] ch,
                                 output result_type res);
      res.status        = st;
      res.address       = (st == ST_OK) ? cur_addr : 32'd0;
      res.prefix_length = (st == ST_OK) ? cur_value[5:0] : 6'd0;
      if (ch == CHAR_NUL) clear_parse();
      else cur_phase = PH_DONE;
      return 1'b1;
   endfunction

   // advance the shadow parser by one character; 1 when a result is due
   function automatic bit parse_char(input logic [7:0] ch, output result_type res);
      logic [7:0] d;
      bit         is_digit;
      bit         got;
      got = 1'b0;
      res = '0;
      d = ch - CHAR_ZERO;
      is_digit = (d < 8'd10);
      case (cur_phase)
         PH_OCTET: begin
            if (is_digit) begin
               add_digit(d);
               if (cur_value > OCTET_MAX) got = decide(ST_OCTET_BIG, ch, res);
            end else if (!cur_has_digit) begin
               got = decide(ST_BAD_SYM, ch, res);
            end else if (cur_octet < LAST_OCTET) begin
               if (ch != CHAR_DOT) begin
                  got = decide(ST_BAD_SYM, ch, res);
               end else begin
                  cur_addr      = {cur_addr[23:0], cur_value[7:0]};
                  cur_octet     = cur_octet + 2'd1;
                  cur_value     = '0;
                  cur_has_digit = 1'b0;
               end
            end else if (ch != CHAR_SLASH) begin
               got = decide(ST_NO_MASK, ch, res);
            end else begin
               cur_addr      = {cur_addr[23:0], cur_value[7:0]};
               cur_value     = '0;
               cur_has_digit = 1'b0;
               cur_phase     = PH_SLASH;
            end
         end
         PH_SLASH: begin
            if (ch == CHAR_NUL) begin
               got = decide(ST_NO_MASK, ch, res);
            end else if (!is_digit) begin
               got = decide(ST_BAD_SYM, ch, res);
            end else begin
               add_digit(d);
               cur_phase = PH_MASK;
               if (cur_value > MASK_MAX) got = decide(ST_MASK_BIG, ch, res);
            end
         end
         PH_MASK: begin
            if (is_digit) begin
               add_digit(d);
               if (cur_value > MASK_MAX) got = decide(ST_MASK_BIG, ch, res);
            end else begin
               got = decide(ST_OK, ch, res);
            end
         end
         default: begin
            if (ch == CHAR_NUL) clear_parse();
         end
      endcase
      return got;
   endfunction

   // idle length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(input logic [7:0] ch, input bit typed, input status_type st,
                          input logic [31:0] addr, input logic [5:0] pfx);
      result_type r;
      r.status        = st;
      r.address       = addr;
      r.prefix_length = pfx;
      dir_chars.push_back(ch);
      dir_typed.push_back(typed);
      dir_results.push_back(r);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, ST_OK, 32'd0, 6'd0);
   endtask

   task automatic push_number(input int v, input bit lead_zero);
      string s;
      s = $sformatf("%0d", v);
      if (lead_zero) text_buf.push_back(CHAR_ZERO);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // one string: mostly well formed with random content, the rest noise
   task automatic build_string();
      int v;
      text_buf.delete();
      if ($urandom_range(0, 99) < 75) begin
         for (int k = 0; k < 4; k++) begin
            v = $urandom_range(0, 99);
            if (v < 10) v = ($urandom_range(0, 1) != 0) ? 255 : 0;
            else if (v < 18) v = $urandom_range(256, 999);
            else v = $urandom_range(0, 255);
            push_number(v, $urandom_range(0, 9) == 0);
            if (k < 3) text_buf.push_back(CHAR_DOT);
         end
         if ($urandom_range(0, 99) < 92) text_buf.push_back(CHAR_SLASH);
         else text_buf.push_back(8'($urandom_range(0, 255)));
         v = $urandom_range(0, 99);
         if (v < 85) push_number($urandom_range(0, 32), $urandom_range(0, 9) == 0);
         else if (v < 95) push_number($urandom_range(33, 999), 1'b0);
         if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
         end
         text_buf.push_back(CHAR_NUL);
         // corrupt one character now and then
         if ($urandom_range(0, 99) < 15)
            text_buf[$urandom_range(0, text_buf.size() - 2)] = 8'($urandom_range(0, 255));
      end else begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         text_buf.push_back(CHAR_NUL);
      end
   endtask

   // offer one character, wait for acceptance, then record what it should yield
   task automatic offer_char(input logic [7:0] ch, input bit steady, input bit typed,
                             input result_type typed_res);
      int         n;
      result_type res;
      bit         got;
      n = steady ? 0 : pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parsed_chars++;
      got = parse_char(ch, res);
      if (typed) pending_results.push_back(typed_res);
      else if (got) pending_results.push_back(res);
   endtask

   // response checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status=%0d address=%h prefix=%0d",
                     $realtime, rsp_status, rsp_address, rsp_prefix_length);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_address !== want.address) begin
               $display("%0t: address expected %h actual %h",
                        $realtime, want.address, rsp_address);
               fail_count++;
            end
            if (rsp_prefix_length !== want.prefix_length) begin
               $display("%0t: prefix_length expected %0d actual %0d",
                        $realtime, want.prefix_length, rsp_prefix_length);
               fail_count++;
            end
         end
      end
   end

   // response side stalls, with one long hold-off to back the block up
   initial begin : rsp_side
      int rounds;
      int n;
      rounds = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         rounds++;
         n = (rounds == 40) ? 300 : pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (1 + pick_gap()) @(posedge clock);
      end
   end

   // request side
   initial begin : req_side
      bit         steady;
      result_type none;
      none = '0;
      clear_parse();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty string
      add_row(CHAR_NUL, 1'b1, ST_BAD_SYM, 32'd0, 6'd0);
      // octet over 255 at its third digit
      add_text("25");
      add_row("6", 1'b1, ST_OCTET_BIG, 32'd0, 6'd0);
      add_row(CHAR_NUL, 1'b0, ST_OK, 32'd0, 6'd0);
      // slash where a dot belongs
      add_text("1");
      add_row(CHAR_SLASH, 1'b1, ST_BAD_SYM, 32'd0, 6'd0);
      add_row(CHAR_NUL, 1'b0, ST_OK, 32'd0, 6'd0);
      // top byte value as the first character
      add_row(8'hFF, 1'b1, ST_BAD_SYM, 32'd0, 6'd0);
      add_row(CHAR_NUL, 1'b0, ST_OK, 32'd0, 6'd0);
      // extremes of octets and mask, ended by the terminator
      add_text("255.0.0.1/32");
      add_row(CHAR_NUL, 1'b1, ST_OK, 32'hFF00_0001, 6'd32);

      for (int i = 0; i < dir_chars.size(); i++)
         offer_char(dir_chars[i], 1'b0, dir_typed[i], dir_results[i]);

      // random strings
      while (parsed_chars < 750) begin
         build_string();
         steady = ($urandom_range(0, 9) < 2);
         foreach (text_buf[i]) offer_char(text_buf[i], steady, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
